>>> rtl/trre_pkg.sv
// ----------------------------------------------------------------------------
// TCP RTT / RTO estimator package
// Shared types, register indexes and arithmetic constants of the estimator.
// ----------------------------------------------------------------------------
package trre_pkg;

    // Stream and configuration port widths
    localparam int unsigned S_TDATA_W  = 232;
    localparam int unsigned S_TUSER_W  = 2;
    localparam int unsigned M_TDATA_W  = 96;
    localparam int unsigned M_TUSER_W  = 1;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMESTAMPS_ON = 2'd0,
        REG_RTO_MIN_MS    = 2'd1,
        REG_RTO_MAX_MS    = 2'd2
    } reg_idx_t;

    // Reset values
    localparam logic [31:0] RESET_RTO_MS     = 32'd1000;
    localparam logic [15:0] RESET_RTO_MIN_MS = 16'd1000;
    localparam logic [31:0] RESET_RTO_MAX_MS = 32'd60000;

    localparam logic [31:0] SAMPLE_MAX = 32'hFFFF_FFFF;

    // Microseconds to milliseconds: drop three bits (divide by 8), then divide
    // by 125 with a reciprocal that underestimates the quotient by at most one.
    localparam int unsigned MS_PRESHIFT    = 3;
    localparam int unsigned MS_RECIP_SHIFT = 38;
    localparam logic [31:0] MS_RECIP       = 32'd2199023255;
    localparam logic [31:0] MS_REM_DIV     = 32'd125;
    localparam int unsigned Q_W            = 64 - MS_RECIP_SHIFT;

    // One received segment
    typedef struct packed {
        logic        syn_flag;
        logic        ack_flag;
        logic [31:0] rtt_sample_us;
        logic        ack_acceptable;
        logic        retransmitting;
        logic        queue_empty;
        logic [31:0] head_end_seq;
        logic [31:0] ack_seq;
        logic [63:0] now_us;
        logic [63:0] head_sent_us;
    } seg_t;

    // Chosen RTT sample
    typedef struct packed {
        logic        have;
        logic [31:0] r;
    } sample_t;

    // Estimator values reported with one result
    typedef struct packed {
        logic        updated;
        logic [31:0] srtt;
        logic [31:0] rttvar;
    } est_t;

    // Estimator values with the raw timeout already divided by eight
    typedef struct packed {
        est_t        est;
        logic [31:0] x;
    } scaled_t;

endpackage

>>> rtl/tcp_rtt_rto_estimator_core.sv
// ----------------------------------------------------------------------------
// TCP RTT / RTO estimator core
// Per-segment RTT sampling, SRTT/RTTVAR smoothing and clamped RTO in ms.
// ----------------------------------------------------------------------------
// Usage:
// Each segment received on one connection is presented as one transfer on the
// s_ channel; every accepted transfer produces exactly one transfer on the m_
// channel carrying the update flag and the current RTO, SRTT and RTTVAR.
// The cfg channel writes the timestamp mode and the RTO clamps; it is always
// ready and should only be used while no segment is in flight.
// An accepted transfer passes every pipeline register before it reaches m_.
// Throughput: one segment per cycle unless m_tready stalls, set by the
// SRTT/RTTVAR update, computed combinationally from the chosen sample.
// The seven pipeline registers hand items on independently, so a stalled
// m_ channel only backs up the pipeline; s_tready falls once every stage is
// holding an item and rises again as soon as m_tready lets the output move.
// Reset empties the pipeline, clears SRTT and RTTVAR, sets the RTO to 1000 ms
// and returns the registers to timestamps off, 1000 ms min and 60000 ms max.
// ----------------------------------------------------------------------------
module tcp_rtt_rto_estimator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // syn_flag, ack_flag
    input  logic [trre_pkg::S_TUSER_W-1:0]    s_tuser,
    // rtt_sample_us, ack_acceptable, retransmitting, queue_empty,
    // head_end_seq, ack_seq, now_us, head_sent_us, zero padding
    input  logic [trre_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // updated
    output logic [trre_pkg::M_TUSER_W-1:0]    m_tuser,
    // rto_ms, srtt_us, rttvar_us
    output logic [trre_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trre_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import trre_pkg::*;

    logic        ts_on_reg;
    logic [15:0] rto_min_reg;
    logic [31:0] rto_max_reg;
    seg_t        in_seg;
    logic        smp_valid;
    logic        smp_ready;
    sample_t     smp;
    logic        scl_valid;
    logic        scl_ready;
    scaled_t     scl;
    est_t        out_est;
    logic [31:0] out_rto;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_on_reg   <= 1'b0;
            rto_min_reg <= RESET_RTO_MIN_MS;
            rto_max_reg <= RESET_RTO_MAX_MS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIMESTAMPS_ON: ts_on_reg   <= cfg_data[0];
                REG_RTO_MIN_MS:    rto_min_reg <= cfg_data[15:0];
                REG_RTO_MAX_MS:    rto_max_reg <= cfg_data[31:0];
                default: begin
                    // Writes to unknown indexes are dropped.
                end
            endcase
        end
    end

    always_comb begin
        in_seg.syn_flag       = s_tuser[0];
        in_seg.ack_flag       = s_tuser[1];
        in_seg.rtt_sample_us  = s_tdata[31:0];
        in_seg.ack_acceptable = s_tdata[32];
        in_seg.retransmitting = s_tdata[33];
        in_seg.queue_empty    = s_tdata[34];
        in_seg.head_end_seq   = s_tdata[66:35];
        in_seg.ack_seq        = s_tdata[98:67];
        in_seg.now_us         = s_tdata[162:99];
        in_seg.head_sent_us   = s_tdata[226:163];
    end

    trre_sample u_sample (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_seg    (in_seg),
        .ts_on     (ts_on_reg),
        .out_valid (smp_valid),
        .out_ready (smp_ready),
        .out_smp   (smp)
    );

    trre_smooth u_smooth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (smp_valid),
        .in_ready  (smp_ready),
        .in_smp    (smp),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_scl   (scl)
    );

    trre_rto u_rto (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_scl    (scl),
        .rto_min   (rto_min_reg),
        .rto_max   (rto_max_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_est   (out_est),
        .out_rto   (out_rto)
    );

    assign m_tuser = out_est.updated;
    assign m_tdata = {out_est.rttvar, out_est.srtt, out_rto};

    // An empty output stage lets every earlier stage advance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    // Every sample is at least one, so an update never leaves SRTT at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[63:32] != 32'd0))
        else $error("update reported with zero SRTT");

    // A result without an update reports the timeout left by earlier results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == $past(m_tdata[31:0])))
        else $error("timeout changed without an RTT update");

endmodule

>>> rtl/trre_sample.sv
// ----------------------------------------------------------------------------
// TCP RTT / RTO estimator sample selection
// Input register and RTT sample choice under Karn's rule or timestamp mode.
// ----------------------------------------------------------------------------
module trre_sample (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  trre_pkg::seg_t   in_seg,
    input  logic             ts_on,
    output logic             out_valid,
    input  logic             out_ready,
    output trre_pkg::sample_t out_smp
);
    import trre_pkg::*;

    logic        a_valid_reg;
    seg_t        a_seg_reg;
    logic        b_valid_reg;
    sample_t     b_smp_reg;
    sample_t     b_smp_next;
    logic        a_ready;
    logic        b_ready;
    logic        pure_syn;
    logic [31:0] seq_diff;
    logic        own_ok;
    logic [64:0] elapsed;
    logic [31:0] measured;

    assign b_ready = !b_valid_reg || out_ready;
    assign a_ready = !a_valid_reg || b_ready;

    always_comb begin
        pure_syn = a_seg_reg.syn_flag && !a_seg_reg.ack_flag;
        // The ACK passes the head segment's end when the wrapped difference is negative.
        seq_diff = a_seg_reg.head_end_seq - a_seg_reg.ack_seq;
        own_ok   = a_seg_reg.ack_acceptable && !a_seg_reg.retransmitting &&
                   !a_seg_reg.queue_empty && seq_diff[31];
        elapsed  = {1'b0, a_seg_reg.now_us} - {1'b0, a_seg_reg.head_sent_us};
        if (elapsed[64] || (elapsed[63:0] == 64'd0)) begin
            measured = 32'd1;
        end else if (|elapsed[63:32]) begin
            measured = SAMPLE_MAX;
        end else begin
            measured = elapsed[31:0];
        end

        b_smp_next.have = 1'b0;
        b_smp_next.r    = measured;
        if (!pure_syn) begin
            if (ts_on) begin
                b_smp_next.have = |a_seg_reg.rtt_sample_us;
                b_smp_next.r    = a_seg_reg.rtt_sample_us;
            end else begin
                b_smp_next.have = own_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_seg_reg <= in_seg;
        end
        if (b_ready && a_valid_reg) begin
            b_smp_reg <= b_smp_next;
        end
    end

    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_smp   = b_smp_reg;

endmodule

>>> rtl/trre_smooth.sv
// ----------------------------------------------------------------------------
// TCP RTT / RTO estimator smoothing
// Holds SRTT and RTTVAR, applies one sample per cycle unless the output stalls, and forms the raw timeout.
// ----------------------------------------------------------------------------
module trre_smooth (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  trre_pkg::sample_t in_smp,
    output logic              out_valid,
    input  logic              out_ready,
    output trre_pkg::scaled_t out_scl
);
    import trre_pkg::*;

    logic [31:0] srtt_reg;
    logic [31:0] srtt_next;
    logic [31:0] rttvar_reg;
    logic [31:0] rttvar_next;
    logic        c_valid_reg;
    est_t        c_est_reg;
    est_t        c_est_next;
    logic        c_first_reg;
    logic        d_valid_reg;
    scaled_t     d_scl_reg;
    scaled_t     d_scl_next;
    logic        c_ready;
    logic        d_ready;
    logic        first;
    logic [31:0] abs_diff;
    logic [33:0] var_sum;
    logic [34:0] srtt_sum;
    logic [34:0] var_term;
    logic [34:0] raw;

    assign d_ready = !d_valid_reg || out_ready;
    assign c_ready = !c_valid_reg || d_ready;

    // Sample update: both new values come from the old SRTT and RTTVAR.
    always_comb begin
        first    = (srtt_reg == 32'd0);
        abs_diff = (srtt_reg > in_smp.r) ? (srtt_reg - in_smp.r) : (in_smp.r - srtt_reg);
        var_sum  = {2'b00, rttvar_reg} + {1'b0, rttvar_reg, 1'b0} + {2'b00, abs_diff};
        srtt_sum = {srtt_reg, 3'b000} - {3'b000, srtt_reg} + {3'b000, in_smp.r};
        if (first) begin
            srtt_next   = in_smp.r;
            rttvar_next = {1'b0, in_smp.r[31:1]};
        end else begin
            srtt_next   = srtt_sum[34:3];
            rttvar_next = var_sum[33:2];
        end

        c_est_next.updated = in_smp.have;
        c_est_next.srtt    = in_smp.have ? srtt_next : srtt_reg;
        c_est_next.rttvar  = in_smp.have ? rttvar_next : rttvar_reg;
    end

    // Raw timeout: three samples on the first measurement, else SRTT plus 4 RTTVAR (plus one when RTTVAR is zero).
    always_comb begin
        var_term = (c_est_reg.rttvar == 32'd0) ? 35'd1 : {1'b0, c_est_reg.rttvar, 2'b00};
        if (c_first_reg) begin
            raw = {3'b000, c_est_reg.srtt} + {2'b00, c_est_reg.srtt, 1'b0};
        end else begin
            raw = {3'b000, c_est_reg.srtt} + var_term;
        end
        d_scl_next.est = c_est_reg;
        d_scl_next.x   = raw[34:MS_PRESHIFT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srtt_reg    <= 32'd0;
            rttvar_reg  <= 32'd0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready && in_valid && in_smp.have) begin
                srtt_reg   <= srtt_next;
                rttvar_reg <= rttvar_next;
            end
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_est_reg   <= c_est_next;
            c_first_reg <= in_smp.have && first;
        end
        if (d_ready && c_valid_reg) begin
            d_scl_reg <= d_scl_next;
        end
    end

    assign in_ready  = c_ready;
    assign out_valid = d_valid_reg;
    assign out_scl   = d_scl_reg;

endmodule

>>> rtl/trre_rto.sv
// ----------------------------------------------------------------------------
// TCP RTT / RTO estimator timeout conversion
// Converts the raw timeout to milliseconds, clamps it and holds the result.
// ----------------------------------------------------------------------------
module trre_rto (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  trre_pkg::scaled_t in_scl,
    input  logic [15:0]       rto_min,
    input  logic [31:0]       rto_max,
    output logic              out_valid,
    input  logic              out_ready,
    output trre_pkg::est_t    out_est,
    output logic [31:0]       out_rto
);
    import trre_pkg::*;

    logic               e_valid_reg;
    est_t               e_est_reg;
    logic [31:0]        e_x_reg;
    logic [Q_W-1:0]     e_q_reg;
    logic [Q_W-1:0]     e_q_next;
    logic               f_valid_reg;
    est_t               f_est_reg;
    logic [Q_W-1:0]     f_ms_reg;
    logic [Q_W-1:0]     f_ms_next;
    logic               g_valid_reg;
    est_t               g_est_reg;
    logic [31:0]        timeout_reg;
    logic [31:0]        timeout_next;
    logic               e_ready;
    logic               f_ready;
    logic               g_ready;
    logic [63:0]        prod;
    logic [31:0]        q_scaled;
    logic [31:0]        rem;
    logic [31:0]        ms_ext;
    logic [31:0]        min_ext;
    logic [31:0]        lo;
    logic [31:0]        clamped;

    assign g_ready = !g_valid_reg || out_ready;
    assign f_ready = !f_valid_reg || g_ready;
    assign e_ready = !e_valid_reg || f_ready;

    always_comb begin
        prod     = {32'd0, in_scl.x} * {32'd0, MS_RECIP};
        e_q_next = prod[63:MS_RECIP_SHIFT];
    end

    // The estimated quotient is low by at most one; one compare corrects it.
    always_comb begin
        q_scaled  = {{(32-Q_W){1'b0}}, e_q_reg} * MS_REM_DIV;
        rem       = e_x_reg - q_scaled;
        f_ms_next = e_q_reg + {{(Q_W-1){1'b0}}, (rem >= MS_REM_DIV)};
    end

    always_comb begin
        ms_ext  = {{(32-Q_W){1'b0}}, f_ms_reg};
        min_ext = {16'd0, rto_min};
        lo      = (ms_ext < min_ext) ? min_ext : ms_ext;
        clamped = (lo > rto_max) ? rto_max : lo;
        timeout_next = f_est_reg.updated ? clamped : timeout_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            timeout_reg <= RESET_RTO_MS;
        end else begin
            if (e_ready) begin
                e_valid_reg <= in_valid;
            end
            if (f_ready) begin
                f_valid_reg <= e_valid_reg;
            end
            if (g_ready) begin
                g_valid_reg <= f_valid_reg;
            end
            if (g_ready && f_valid_reg) begin
                timeout_reg <= timeout_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_ready && in_valid) begin
            e_est_reg <= in_scl.est;
            e_x_reg   <= in_scl.x;
            e_q_reg   <= e_q_next;
        end
        if (f_ready && e_valid_reg) begin
            f_est_reg <= e_est_reg;
            f_ms_reg  <= f_ms_next;
        end
        if (g_ready && f_valid_reg) begin
            g_est_reg <= f_est_reg;
        end
    end

    assign in_ready  = e_ready;
    assign out_valid = g_valid_reg;
    assign out_est   = g_est_reg;
    assign out_rto   = timeout_reg;

endmodule
